@@ rtl/spwm_pkg.sv @@
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared widths, constants and interface types of the multiphase sine PWM
// compare unit.
// ----------------------------------------------------------------------------
package spwm_pkg;

	localparam int CH_W     = 2;   // phase index on the result side
	localparam int PTR_W    = 12;  // stored sample pointer
	localparam int PERIOD_W = 16;  // PWM period register
	localparam int ROM_W    = 17;  // unsigned Q1.16 sine sample, 0 .. 65536
	localparam int CMP_W    = 16;  // compare value
	localparam int IN_W     = 8;   // input tdata, byte padded
	localparam int FRAC_W   = 16;  // fraction bits of the sine sample

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// one request to the pointer store; read and write never share a cycle
	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic             clear;
		logic [CH_W-1:0]  addr;
		logic [PTR_W-1:0] wr_data;
	} ptr_req_t;

endpackage

@@ rtl/spwm_ptr_store.sv @@
// ----------------------------------------------------------------------------
// spwm_ptr_store
// Per-phase sample pointer memory with a registered read. A valid bit
// per entry makes a never-written or cleared entry read as its phase offset.
// ----------------------------------------------------------------------------
module spwm_ptr_store #(
	parameter int SAMPLES = 256,
	parameter int PHASES  = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spwm_pkg::ptr_req_t            req,
	output logic [spwm_pkg::PTR_W-1:0]    rd_data_s1
);

	localparam int PH_W = (PHASES > 1) ? $clog2(PHASES) : 1;

	logic [spwm_pkg::PTR_W-1:0] mem [PHASES];
	logic [spwm_pkg::PTR_W-1:0] offset [PHASES];
	logic [PHASES-1:0]          valid_q;
	logic [PH_W-1:0]            addr;

	assign addr = req.addr[PH_W-1:0];

	for (genvar k = 0; k < PHASES; k++) begin : g_offset
		assign offset[k] = spwm_pkg::PTR_W'(k * SAMPLES / PHASES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[addr] <= 1'b1;
		end
	end

	// a clear in the same cycle as a read wins: reload the offset
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_s1 <= (req.clear || !valid_q[addr]) ? offset[addr] : mem[addr];
		end
	end

endmodule

@@ rtl/spwm_sine_rom.sv @@
// ----------------------------------------------------------------------------
// spwm_sine_rom
// Raised sine table, (sin(2*pi*i/SAMPLES)+1)/2 in unsigned Q1.16, built at
// elaboration and read synchronously.
// ----------------------------------------------------------------------------
module spwm_sine_rom #(
	parameter int SAMPLES = 256
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(SAMPLES)-1:0]    addr,
	output logic [spwm_pkg::ROM_W-1:0]    rd_data_s1
);

	// quadrant fold, Taylor series to x^13 in Q30, round half up to Q1.16
	function automatic logic [spwm_pkg::ROM_W-1:0] rom_entry(input int unsigned i);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] acc;
		q = 64'(4 * i) / 64'(SAMPLES);
		r = 64'(4 * i) - q * 64'(SAMPLES);
		if (q[0]) begin
			r = 64'(SAMPLES) - r;
		end
		x    = (r * spwm_pkg::HALF_PI_Q30) / 64'(SAMPLES);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		if (sum > spwm_pkg::Q30_ONE) begin
			sum = spwm_pkg::Q30_ONE;
		end
		acc = (q >= 64'd2) ? spwm_pkg::Q30_ONE - sum : spwm_pkg::Q30_ONE + sum;
		return spwm_pkg::ROM_W'((acc + 64'd16384) >> 15);
	endfunction

	logic [spwm_pkg::ROM_W-1:0] rom_tbl [SAMPLES];

	for (genvar i = 0; i < SAMPLES; i++) begin : g_rom
		localparam logic [spwm_pkg::ROM_W-1:0] ENTRY = rom_entry(i);
		assign rom_tbl[i] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= rom_tbl[addr];
		end
	end

endmodule

@@ rtl/multiphase_sine_pwm_compare_unit.sv @@
// Timing: per phase, a registered pointer read, then a registered sine lookup,
// then the scaled result into the output register; phases follow in order.
// Throughput: a new tick is taken only when idle, after the last phase's
// result is registered; an output stall holds the sequence.
// Reset: pointers read as their phase offsets, period returns to 1000,
// output channel empty.
// ----------------------------------------------------------------------------
// multiphase_sine_pwm_compare_unit
// Gives one PWM compare value per phase for every tick, each from the phase's
// own pointer into a raised sine table scaled by the PWM period.
// ----------------------------------------------------------------------------
module multiphase_sine_pwm_compare_unit #(
	parameter int SAMPLES = 256,
	parameter int PHASES  = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: pwm_period
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spwm_pkg::PERIOD_W-1:0]    cfg_data,
	// tick input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [spwm_pkg::IN_W-1:0]        s_tdata,   // [0] restart, [7:1] zero
	// compare results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spwm_pkg::CMP_W-1:0]       m_tdata,   // [15:0] compare
	output logic [spwm_pkg::CH_W-1:0]        m_tuser,   // [1:0] channel
	output logic                             m_tlast
);

	localparam int IDX_W  = $clog2(SAMPLES);
	localparam int PROD_W = spwm_pkg::ROM_W + spwm_pkg::PERIOD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MUL
	} state_t;

	state_t                        state_q;
	logic [spwm_pkg::CH_W-1:0]     phase_q;
	logic [spwm_pkg::PERIOD_W-1:0] period_q;
	logic                          m_tvalid_q;
	logic [spwm_pkg::CMP_W-1:0]    m_tdata_q;
	logic [spwm_pkg::CH_W-1:0]     m_tuser_q;
	logic                          m_tlast_q;

	spwm_pkg::ptr_req_t            ptr_req;
	logic [spwm_pkg::PTR_W-1:0]    ptr_rd;
	logic [spwm_pkg::ROM_W-1:0]    rom_rd;

	logic                          in_range;
	logic [IDX_W-1:0]              idx;
	logic [IDX_W:0]                idx_nxt;
	logic                          wrap;
	logic [PROD_W-1:0]             product;
	logic                          out_free;
	logic                          last_phase;
	logic                          accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// pointer at or past the table end reads entry 0
	assign in_range = {1'b0, ptr_rd} < (spwm_pkg::PTR_W + 1)'(SAMPLES);
	assign idx      = in_range ? ptr_rd[IDX_W-1:0] : '0;
	assign idx_nxt  = (IDX_W + 1)'(idx) + (IDX_W + 1)'(1);
	assign wrap     = (idx_nxt == (IDX_W + 1)'(SAMPLES));

	assign product    = PROD_W'(rom_rd) * PROD_W'(period_q);
	assign out_free   = !m_tvalid_q || m_tready;
	assign last_phase = (phase_q == spwm_pkg::CH_W'(PHASES - 1));

	always_comb begin
		ptr_req      = '0;
		ptr_req.addr = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				ptr_req.rd_en = accept;
				ptr_req.clear = accept && s_tdata[0];
				ptr_req.addr  = '0;
			end
			ST_LOOK: begin
				ptr_req.wr_en   = 1'b1;
				ptr_req.wr_data = wrap ? '0 : spwm_pkg::PTR_W'(idx_nxt);
			end
			ST_MUL: begin
				ptr_req.rd_en = out_free && !last_phase;
				ptr_req.addr  = phase_q + spwm_pkg::CH_W'(1);
			end
			default: begin
				ptr_req = '0;
			end
		endcase
	end

	spwm_ptr_store #(
		.SAMPLES (SAMPLES),
		.PHASES  (PHASES)
	) u_ptr_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (ptr_req),
		.rd_data_s1 (ptr_rd)
	);

	spwm_sine_rom #(
		.SAMPLES (SAMPLES)
	) u_sine_rom (
		.clk        (clk),
		.rd_en      (state_q == ST_LOOK),
		.addr       (idx),
		.rd_data_s1 (rom_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= spwm_pkg::PERIOD_RESET;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// in ST_MUL the arm below owns the valid flag
			if (m_tready && state_q != ST_MUL) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// hold the scaled sample until the output slot frees up
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= product[spwm_pkg::FRAC_W +: spwm_pkg::CMP_W];
						m_tuser_q  <= phase_q;
						m_tlast_q  <= last_phase;
						if (last_phase) begin
							state_q <= ST_IDLE;
						end else begin
							phase_q <= phase_q + spwm_pkg::CH_W'(1);
							state_q <= ST_LOOK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_start_phase0: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_LOOK && phase_q == '0)
		else $error("tick did not start at phase 0");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOK |-> in_range)
		else $error("stored pointer beyond table");

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == spwm_pkg::CH_W'(PHASES - 1))
		else $error("last flag on wrong channel");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL && m_tvalid && !m_tready |=> state_q == ST_MUL)
		else $error("result advanced while output stalled");
`endif

endmodule
